/* hdl/wsm_pkg.sv */
// ----------------------------------------------------------------------------
// wsm_pkg
// Shared constants, codes and controller/datapath interface types for the
// wildcard socket match table.
// ----------------------------------------------------------------------------
package wsm_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic       load;
    logic       scan_clr;
    logic       scan_step;
    logic       write_add;
    logic       clear_rm;
    logic       pass_end;
    logic       pend_load;
    logic       emit;
    logic       emit_pend;
    logic       emit_last;
    logic [1:0] emit_status;
  } wsm_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       scan_last;
    logic       hit;
    logic       free_found;
    logic       best_found;
    logic       pend_valid;
    logic       out_free;
  } wsm_sts_t;

endpackage

/* hdl/wsm_datapath.sv */
// ----------------------------------------------------------------------------
// wsm_datapath
// Socket table storage, per-entry scan compare, pending match and output
// register.
// ----------------------------------------------------------------------------
module wsm_datapath (
  input  logic             clk,
  input  logic             rst,
  input  wsm_pkg::wsm_cmd_t cmd,
  output wsm_pkg::wsm_sts_t sts,
  input  logic [1:0]       opcode,
  input  logic [15:0]      sock_id,
  input  logic [47:0]      local_mac,
  input  logic [47:0]      remote_mac,
  input  logic [7:0]       proto_id,
  input  logic             steal_flag,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status,
  output logic             match_found,
  output logic [15:0]      match_id,
  output logic             match_steal,
  output logic             last
);
  import wsm_pkg::*;

  logic [TABLE_DEPTH-1:0] ent_valid;
  logic [15:0]            ent_id     [TABLE_DEPTH];
  logic [47:0]            ent_local  [TABLE_DEPTH];
  logic [47:0]            ent_remote [TABLE_DEPTH];
  logic [7:0]             ent_proto  [TABLE_DEPTH];
  logic                   ent_steal  [TABLE_DEPTH];

  logic [1:0]  req_op;
  logic [15:0] req_id;
  logic [47:0] req_local;
  logic [47:0] req_remote;
  logic [7:0]  req_proto;
  logic        req_steal;

  logic [IDX_W-1:0] idx;
  logic             hit;
  logic [IDX_W-1:0] hit_slot;
  logic             free_found;
  logic [IDX_W-1:0] free_slot;
  logic             have_prev;
  logic [15:0]      prev_id;
  logic             best_found;
  logic [15:0]      best_id;
  logic             best_steal;
  logic             pend_valid;
  logic [15:0]      pend_id;
  logic             pend_steal;

  logic cur_valid, cur_hit, cur_match, cur_better;
  logic [15:0] cur_id;
  logic [47:0] cur_local, cur_remote;
  logic [7:0]  cur_proto;

  always_comb begin
    cur_valid  = ent_valid[idx];
    cur_id     = ent_id[idx];
    cur_local  = ent_local[idx];
    cur_remote = ent_remote[idx];
    cur_proto  = ent_proto[idx];
    cur_hit    = cur_valid && (cur_id == req_id);
    cur_match  = cur_valid
                 && (!have_prev || (cur_id > prev_id))
                 && ((cur_local == 48'd0) || (req_local == MAC_BCAST)
                     || (req_local == cur_local))
                 && ((cur_remote == 48'd0) || (req_remote == MAC_BCAST)
                     || (req_remote == cur_remote))
                 && ((cur_proto == 8'd0) || (req_proto == cur_proto));
    cur_better = cur_match && (!best_found || (cur_id < best_id));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op     <= opcode;
      req_id     <= sock_id;
      req_local  <= local_mac;
      req_remote <= remote_mac;
      req_proto  <= proto_id;
      req_steal  <= steal_flag;
    end
    if (cmd.write_add) begin
      ent_id[free_slot]     <= req_id;
      ent_local[free_slot]  <= req_local;
      ent_remote[free_slot] <= req_remote;
      ent_proto[free_slot]  <= req_proto;
      ent_steal[free_slot]  <= req_steal;
    end
    if (cmd.scan_step) begin
      if (cur_hit) hit_slot <= idx;
      if (!free_found && !cur_valid) free_slot <= idx;
      if (cur_better) begin
        best_id    <= cur_id;
        best_steal <= ent_steal[idx];
      end
    end
    if (cmd.pass_end) prev_id <= best_id;
    if (cmd.pend_load) begin
      pend_id    <= best_id;
      pend_steal <= best_steal;
    end
    if (cmd.emit) begin
      status      <= cmd.emit_status;
      match_found <= cmd.emit_pend;
      match_id    <= cmd.emit_pend ? pend_id : 16'd0;
      match_steal <= cmd.emit_pend ? pend_steal : 1'b0;
      last        <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid  <= '0;
      idx        <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      best_found <= 1'b0;
      have_prev  <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.write_add) ent_valid[free_slot] <= 1'b1;
      if (cmd.clear_rm) ent_valid[hit_slot] <= 1'b0;
      if (cmd.load) begin
        have_prev  <= 1'b0;
        pend_valid <= 1'b0;
      end
      if (cmd.scan_clr) begin
        idx        <= '0;
        hit        <= 1'b0;
        free_found <= 1'b0;
        best_found <= 1'b0;
      end else if (cmd.scan_step) begin
        idx <= idx + 1'b1;
        if (cur_hit) hit <= 1'b1;
        if (!cur_valid) free_found <= 1'b1;
        if (cur_better) best_found <= 1'b1;
      end
      if (cmd.pass_end) have_prev <= 1'b1;
      if (cmd.pend_load) pend_valid <= 1'b1;
      else if (cmd.emit && cmd.emit_pend) pend_valid <= 1'b0;
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_comb begin
    sts.op         = req_op;
    sts.scan_last  = (idx == IDX_W'(TABLE_DEPTH - 1));
    sts.hit        = hit;
    sts.free_found = free_found;
    sts.best_found = best_found;
    sts.pend_valid = pend_valid;
    sts.out_free   = !out_valid || !out_stall;
  end

endmodule

/* hdl/wsm_ctrl.sv */
// ----------------------------------------------------------------------------
// wsm_ctrl
// Sequencer for add, remove and find: runs table scans and issues results.
// ----------------------------------------------------------------------------
module wsm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  wsm_pkg::wsm_sts_t sts,
  output wsm_pkg::wsm_cmd_t cmd
);
  import wsm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;

  logic [1:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (sts.out_free) begin
          case (sts.op)
            OP_ADD: begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              if (sts.hit) begin
                cmd.emit_status = ST_DUP;
              end else if (!sts.free_found) begin
                cmd.emit_status = ST_FULL;
              end else begin
                cmd.write_add   = 1'b1;
                cmd.emit_status = ST_OK;
              end
              state_next = S_IDLE;
            end
            OP_REMOVE: begin
              cmd.emit        = 1'b1;
              cmd.emit_last   = 1'b1;
              cmd.clear_rm    = sts.hit;
              cmd.emit_status = sts.hit ? ST_OK : ST_NOTFOUND;
              state_next      = S_IDLE;
            end
            OP_FIND: begin
              cmd.emit_status = ST_OK;
              if (sts.best_found) begin
                cmd.emit      = sts.pend_valid;
                cmd.emit_pend = sts.pend_valid;
                cmd.pend_load = 1'b1;
                cmd.pass_end  = 1'b1;
                cmd.scan_clr  = 1'b1;
                state_next    = S_SCAN;
              end else begin
                cmd.emit      = 1'b1;
                cmd.emit_pend = sts.pend_valid;
                cmd.emit_last = 1'b1;
                state_next    = S_IDLE;
              end
            end
            default: begin
              cmd.emit        = 1'b1;
              cmd.emit_last   = 1'b1;
              cmd.emit_status = ST_OK;
              state_next      = S_IDLE;
            end
          endcase
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free) else $error("result issued into a full output");
  a_add_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.write_add |-> (!sts.hit && sts.free_found)) else $error("bad add write");
  a_scan_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |=> (state != S_IDLE) || $past(sts.scan_last))
    else $error("scan left early");
  a_pend_match: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_pend |-> (sts.pend_valid && sts.op == OP_FIND))
    else $error("match result without pending entry");

endmodule

/* hdl/wildcard_socket_match_table.sv */
// ----------------------------------------------------------------------------
// wildcard_socket_match_table
// Socket table with wildcard MAC and protocol lookup.
// ----------------------------------------------------------------------------
// One request at a time; in_stall is high from acceptance until the final
// result has been placed in the output register. Every request scans all
// TABLE_DEPTH entries one per cycle, then decides in S_EVAL, waiting there
// while the output register is stalled. A find repeats the scan once per
// match to pick the next larger socket id.
module wildcard_socket_match_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [15:0] sock_id,
  input  logic [47:0] local_mac,
  input  logic [47:0] remote_mac,
  input  logic [7:0]  proto_id,
  input  logic        steal_flag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        match_found,
  output logic [15:0] match_id,
  output logic        match_steal,
  output logic        last
);
  import wsm_pkg::*;

  wsm_cmd_t cmd;
  wsm_sts_t sts;

  wsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  wsm_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .opcode      (opcode),
    .sock_id     (sock_id),
    .local_mac   (local_mac),
    .remote_mac  (remote_mac),
    .proto_id    (proto_id),
    .steal_flag  (steal_flag),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .match_found (match_found),
    .match_id    (match_id),
    .match_steal (match_steal),
    .last        (last)
  );

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wildcard socket match table. It drives add,
// remove, find and unused-opcode requests with bursty valid and a stalling
// receiver. A local copy of the socket table predicts every result, and each
// accepted result is checked in order against that prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wsm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [15:0] id;
    logic        steal;
    logic        last;
  } sock_result_t;

  class socket_scoreboard;
    bit          tbl_valid [TABLE_DEPTH];
    logic [15:0] tbl_id    [TABLE_DEPTH];
    logic [47:0] tbl_local [TABLE_DEPTH];
    logic [47:0] tbl_remote[TABLE_DEPTH];
    logic [7:0]  tbl_proto [TABLE_DEPTH];
    logic        tbl_steal [TABLE_DEPTH];
    sock_result_t expected_results[$];
    int mismatches;
    int checked;
    int hit_finds;
    int full_seen;

    function int slot_of(logic [15:0] id);
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (tbl_valid[i] && tbl_id[i] == id) return i;
      return -1;
    endfunction

    function bit entry_hit(int i, logic [47:0] loc, logic [47:0] rem, logic [7:0] proto);
      if (tbl_local[i] != 0 && loc != MAC_BCAST && loc != tbl_local[i]) return 0;
      if (tbl_remote[i] != 0 && rem != MAC_BCAST && rem != tbl_remote[i]) return 0;
      if (tbl_proto[i] != 0 && proto != tbl_proto[i]) return 0;
      return 1;
    endfunction

    function void push(logic [1:0] st, logic f, logic [15:0] id, logic s, logic l);
      sock_result_t r;
      r.status = st; r.found = f; r.id = id; r.steal = s; r.last = l;
      expected_results = {expected_results, r};
    endfunction

    function void note_request(logic [1:0] op, logic [15:0] id, logic [47:0] loc,
                               logic [47:0] rem, logic [7:0] proto, logic steal);
      int s;
      int best;
      int prev;
      int n;
      case (op)
        OP_ADD: begin
          s = -1;
          if (slot_of(id) >= 0) push(ST_DUP, 0, 0, 0, 1);
          else begin
            for (int i = TABLE_DEPTH - 1; i >= 0; i--) if (!tbl_valid[i]) s = i;
            if (s < 0) begin
              push(ST_FULL, 0, 0, 0, 1);
              full_seen++;
            end else begin
              tbl_valid[s] = 1; tbl_id[s] = id; tbl_local[s] = loc;
              tbl_remote[s] = rem; tbl_proto[s] = proto; tbl_steal[s] = steal;
              push(ST_OK, 0, 0, 0, 1);
            end
          end
        end
        OP_REMOVE: begin
          s = slot_of(id);
          if (s < 0) push(ST_NOTFOUND, 0, 0, 0, 1);
          else begin
            tbl_valid[s] = 0;
            push(ST_OK, 0, 0, 0, 1);
          end
        end
        OP_FIND: begin
          prev = -1;
          n = 0;
          forever begin
            best = -1;
            for (int i = 0; i < TABLE_DEPTH; i++)
              if (tbl_valid[i] && int'(tbl_id[i]) > prev && entry_hit(i, loc, rem, proto))
                if (best < 0 || tbl_id[i] < tbl_id[best]) best = i;
            if (best < 0) break;
            push(ST_OK, 1, tbl_id[best], tbl_steal[best], 0);
            prev = int'(tbl_id[best]);
            n++;
          end
          if (n == 0) push(ST_OK, 0, 0, 0, 1);
          else begin
            expected_results[$].last = 1;
            hit_finds++;
          end
        end
        default: push(ST_OK, 0, 0, 0, 1);
      endcase
    endfunction

    function void check_result(sock_result_t got);
      sock_result_t exp_r;
      checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = expected_results.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("mismatch: expected st=%0d found=%0b id=%h steal=%0b last=%0b, ",
                 exp_r.status, exp_r.found, exp_r.id, exp_r.steal, exp_r.last);
          $display("got st=%0d found=%0b id=%h steal=%0b last=%0b",
                   got.status, got.found, got.id, got.steal, got.last);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] opcode = 0;
  logic [15:0] sock_id = 0;
  logic [47:0] local_mac = 0;
  logic [47:0] remote_mac = 0;
  logic [7:0] proto_id = 0;
  logic steal_flag = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] status;
  logic match_found;
  logic [15:0] match_id;
  logic match_steal;
  logic last;

  socket_scoreboard sb = new();
  int burst_left = 0;
  int requests = 0;
  int cycle_count = 0;
  logic [15:0] id_pool[8];
  logic [47:0] mac_pool[4];

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  wildcard_socket_match_table dut (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall)
      sb.check_result({status, match_found, match_id, match_steal, last});
    case ((cycle_count / 1500) % 3)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 2) != 0);
    endcase
  end

  task automatic send_request(logic [1:0] op, logic [15:0] id, logic [47:0] loc,
                              logic [47:0] rem, logic [7:0] proto, logic steal);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    opcode <= op; sock_id <= id; local_mac <= loc; remote_mac <= rem;
    proto_id <= proto; steal_flag <= steal;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, id, loc, rem, proto, steal);
    requests++;
  endtask

  function automatic logic [47:0] pick_mac();
    case ($urandom_range(0, 5))
      0: return 48'h0;
      1: return MAC_BCAST;
      2, 3: return mac_pool[$urandom_range(0, 3)];
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [15:0] pick_id();
    return ($urandom_range(0, 4) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, 7)];
  endfunction

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 3))
      0: return 8'h0;
      1: return 8'($urandom);
      default: return 8'($urandom_range(1, 3));
    endcase
  endfunction

  initial begin
    int r;
    logic [1:0] op;
    foreach (id_pool[i]) id_pool[i] = 16'($urandom);
    foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom, $urandom});
    repeat (7) @(posedge clk);
    rst <= 0;

    send_request(OP_ADD, 16'h0000, 48'h0, 48'h0, 8'h0, 1);
    send_request(OP_ADD, 16'hFFFF, MAC_BCAST, MAC_BCAST, 8'hFF, 0);
    send_request(OP_ADD, 16'h0000, 48'h1, 48'h2, 8'h5, 0);
    send_request(OP_ADD, 16'h1234, mac_pool[0], 48'h0, 8'h7, 1);
    send_request(OP_FIND, 0, MAC_BCAST, MAC_BCAST, 8'h7, 0);
    send_request(OP_FIND, 0, mac_pool[0], mac_pool[1], 8'h0, 0);
    send_request(OP_FIND, 0, MAC_BCAST, MAC_BCAST, 8'hFF, 0);
    send_request(OP_FIND, 0, 48'h0, 48'h0, 8'h9, 0);
    send_request(OP_REMOVE, 16'h4321, 0, 0, 0, 0);
    send_request(OP_REMOVE, 16'h0000, 0, 0, 0, 0);
    send_request(OP_UNUSED, 16'h1234, MAC_BCAST, MAC_BCAST, 8'hFF, 1);
    for (int i = 0; i < 14; i++)
      send_request(OP_ADD, 16'(16'h0100 + 7 * i), 48'h0, 48'h0, 8'h0, i[0]);
    send_request(OP_ADD, 16'hBEEF, 48'h0, 48'h0, 8'h0, 0);
    send_request(OP_FIND, 0, 48'h0, 48'h0, 8'h0, 0);
    for (int i = 0; i < 14; i++)
      send_request(OP_REMOVE, 16'(16'h0100 + 7 * i), 0, 0, 0, 0);

    for (int n = 0; n < 300; n++) begin
      r = $urandom_range(0, 99);
      op = r < 30 ? OP_ADD : r < 50 ? OP_REMOVE : r < 96 ? OP_FIND : OP_UNUSED;
      send_request(op, pick_id(), pick_mac(), pick_mac(), pick_proto(), 1'($urandom));
    end

    in_valid <= 0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("covered %0d requests, %0d results checked", requests, sb.checked);
    $display("finds with hits: %0d, full-table adds: %0d", sb.hit_finds, sb.full_seen);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end
endmodule
